// File: design/gfb_pkg.sv
// ============================================================================
// gfb_pkg
// Shared types and constants for the binary command frame builder: the sync
// bytes, the payload length limit and the job record passed front to back.
// ============================================================================
`default_nettype none

package gfb_pkg;

    // Frame constants
    localparam logic [7:0] SYNC_FIRST      = 8'hB5;
    localparam logic [7:0] SYNC_SECOND     = 8'h62;
    localparam logic [7:0] LEN_HIGH        = 8'h00;
    localparam logic [7:0] MAX_PAYLOAD_LEN = 8'd255;

    // Default depth of the job queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Input item kinds (tuser of the slave side)
    localparam logic CMD_HEADER  = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    // Kind of job the back end serialises
    typedef enum logic [1:0] {
        KIND_HDR,
        KIND_PAY,
        KIND_ERR
    } t_kind;

    // One classified request: everything the back end needs to emit its bytes
    typedef struct packed {
        t_kind      kind;
        logic       close;   // checksum bytes follow, frame ends
        logic [7:0] data0;   // class on header, payload byte on payload
        logic [7:0] data1;   // message id
        logic [7:0] data2;   // length low byte
        logic [7:0] ck_a;
        logic [7:0] ck_b;
    } t_job;

endpackage

`default_nettype wire

// File: design/gfb_front.sv
// ============================================================================
// gfb_front
// Accepts header and payload requests, keeps the frame state and the two
// Fletcher sums, and pushes one classified job per request into the queue.
// ============================================================================
`default_nettype none

module gfb_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire               i_cmd,
    input  wire  [7:0]        i_frame_class,
    input  wire  [7:0]        i_message_id,
    input  wire  [7:0]        i_payload_length,
    input  wire  [7:0]        i_payload_byte,
    input  wire               i_queue_full,
    output logic              o_push,
    output gfb_pkg::t_job     o_job
);
    import gfb_pkg::*;

    logic       r_frame_open, n_frame_open;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic [7:0] r_sum_a, n_sum_a;
    logic [7:0] r_sum_b, n_sum_b;

    logic       accept;
    logic [7:0] len_sat;
    logic [7:0] ha1, hb1, ha2, hb2, ha3, hb3, hb4;
    logic [7:0] pay_a, pay_b, pay_left;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;

    // Saturate the length and fold class, id, length low and length high
    assign len_sat = (i_payload_length > MAX_PAYLOAD_LEN) ? MAX_PAYLOAD_LEN
                                                          : i_payload_length;
    assign ha1 = i_frame_class;
    assign hb1 = i_frame_class;
    assign ha2 = ha1 + i_message_id;
    assign hb2 = hb1 + ha2;
    assign ha3 = ha2 + len_sat;
    assign hb3 = hb2 + ha3;
    assign hb4 = hb3 + ha3 + LEN_HIGH;

    // Fold one payload byte into the running sums
    assign pay_a    = r_sum_a + i_payload_byte;
    assign pay_b    = r_sum_b + pay_a;
    assign pay_left = r_bytes_left - 8'd1;

    // Classify the request and work out the next frame state
    always_comb begin
        n_frame_open = r_frame_open;
        n_bytes_left = r_bytes_left;
        n_sum_a      = r_sum_a;
        n_sum_b      = r_sum_b;
        o_job        = '0;
        o_job.data1  = i_message_id;
        o_job.data2  = len_sat;
        if (i_cmd == CMD_HEADER) begin
            o_job.kind   = KIND_HDR;
            o_job.data0  = i_frame_class;
            o_job.close  = (len_sat == 8'd0);
            o_job.ck_a   = ha3;
            o_job.ck_b   = hb4;
            n_sum_a      = ha3;
            n_sum_b      = hb4;
            n_bytes_left = len_sat;
            n_frame_open = (len_sat != 8'd0);
        end else if (r_frame_open) begin
            o_job.kind   = KIND_PAY;
            o_job.data0  = i_payload_byte;
            o_job.close  = (pay_left == 8'd0);
            o_job.ck_a   = pay_a;
            o_job.ck_b   = pay_b;
            n_sum_a      = pay_a;
            n_sum_b      = pay_b;
            n_bytes_left = pay_left;
            n_frame_open = (pay_left != 8'd0);
        end else begin
            o_job.kind   = KIND_ERR;
        end
    end

    // Hold frame state; update only on an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b0;
            r_bytes_left <= 8'd0;
            r_sum_a      <= 8'd0;
            r_sum_b      <= 8'd0;
        end else if (accept) begin
            r_frame_open <= n_frame_open;
            r_bytes_left <= n_bytes_left;
            r_sum_a      <= n_sum_a;
            r_sum_b      <= n_sum_b;
        end
    end

    // An open frame always has bytes to come, a closed one none
    a_open_matches_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_open == (r_bytes_left != 8'd0))
        else $error("frame open flag disagrees with byte count");

endmodule

`default_nettype wire

// File: design/gfb_queue.sv
// ============================================================================
// gfb_queue
// Short first-in first-out queue of jobs that decouples the front end from
// the back end so that each side can stall on its own.
// ============================================================================
`default_nettype none

module gfb_queue #(
    parameter int DEPTH = gfb_pkg::QUEUE_DEPTH_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  gfb_pkg::t_job     i_job,
    output logic              o_full,
    input  wire               i_pop,
    output logic              o_valid,
    output gfb_pkg::t_job     o_job
);
    import gfb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_slot[r_rd_ptr];

    // Store the pushed job
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and track the fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("job popped from an empty queue");

endmodule

`default_nettype wire

// File: design/gfb_back.sv
// ============================================================================
// gfb_back
// Serialises the job at the head of the queue into frame bytes, one per
// cycle, through an output register that the downstream side may stall.
// ============================================================================
`default_nettype none

module gfb_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_job_valid,
    input  gfb_pkg::t_job     i_job,
    output logic              o_pop,
    output logic              o_valid,
    input  wire               i_ready,
    output logic [7:0]        o_frame_byte,
    output logic              o_frame_end,
    output logic              o_last_of_run,
    output logic              o_protocol_error
);
    import gfb_pkg::*;

    logic [2:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_end, r_last, r_err;

    logic       advance;
    logic [2:0] last_idx;
    logic       is_last;
    logic [7:0] sel_byte;

    assign o_valid          = r_valid;
    assign o_frame_byte     = r_byte;
    assign o_frame_end      = r_end;
    assign o_last_of_run    = r_last;
    assign o_protocol_error = r_err;

    assign advance = i_job_valid && (!r_valid || i_ready);
    assign is_last = (r_idx == last_idx);
    assign o_pop   = advance && is_last;

    // Pick the byte for the current position within the job
    always_comb begin
        last_idx = 3'd0;
        sel_byte = 8'h00;
        unique case (i_job.kind)
            KIND_HDR: begin
                last_idx = i_job.close ? 3'd7 : 3'd5;
                unique case (r_idx)
                    3'd0:    sel_byte = SYNC_FIRST;
                    3'd1:    sel_byte = SYNC_SECOND;
                    3'd2:    sel_byte = i_job.data0;
                    3'd3:    sel_byte = i_job.data1;
                    3'd4:    sel_byte = i_job.data2;
                    3'd5:    sel_byte = LEN_HIGH;
                    3'd6:    sel_byte = i_job.ck_a;
                    default: sel_byte = i_job.ck_b;
                endcase
            end
            KIND_PAY: begin
                last_idx = i_job.close ? 3'd2 : 3'd0;
                unique case (r_idx)
                    3'd0:    sel_byte = i_job.data0;
                    3'd1:    sel_byte = i_job.ck_a;
                    default: sel_byte = i_job.ck_b;
                endcase
            end
            default: begin
                last_idx = 3'd0;
                sel_byte = 8'h00;
            end
        endcase
    end

    // Advance through the job and load the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_idx   <= is_last ? 3'd0 : r_idx + 3'd1;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_byte <= sel_byte;
            r_last <= is_last;
            r_end  <= is_last && i_job.close && (i_job.kind != KIND_ERR);
            r_err  <= (i_job.kind == KIND_ERR);
        end
    end

    // Part way through a job, the job must still sit at the queue head
    a_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 3'd0) |-> i_job_valid)
        else $error("job left the queue before all its bytes were sent");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_end) |-> (r_last && !r_err))
        else $error("frame end on a byte that does not close the request");

endmodule

`default_nettype wire

// File: design/gnss_binary_frame_builder.sv
// ============================================================================
// gnss_binary_frame_builder
// Turns header and payload requests into framed binary receiver commands
// with sync bytes and an 8-bit Fletcher checksum.
// ============================================================================
// A header request (tuser 0) emits sync 0xB5 0x62, class, id, length low and
// length high (always zero) - six bytes, eight when the length is zero, since
// the two checksum bytes then follow at once. Each payload request (tuser 1)
// emits its byte, plus ck_a and ck_b after the final byte of the frame. A
// payload request with no open frame gives a single zero byte flagged as a
// protocol error; a header request abandons any open frame. Lengths above
// MAX_PAYLOAD_LEN are saturated. Requests are taken one per cycle while the
// job queue (QUEUE_DEPTH entries) has room; the output side delivers one byte
// per cycle from a registered stage while the receiver is ready, and the byte
// serialiser behind the queue paces the output.
// ============================================================================
`default_nettype none

module gnss_binary_frame_builder #(
    parameter int QUEUE_DEPTH = gfb_pkg::QUEUE_DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] frame_class, [15:8] message_id, [23:16] payload_length,
    // [31:24] payload_byte
    input  wire  [31:0] s_axis_tdata,
    // [0] cmd
    input  wire         s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [7:0] frame_byte
    output logic [7:0]  m_axis_tdata,
    // frame_end
    output logic        m_axis_tlast,
    // [0] last_of_run, [1] protocol_error
    output logic [1:0]  m_axis_tuser
);
    import gfb_pkg::*;

    logic q_full, q_valid, q_push, q_pop;
    t_job push_job, head_job;
    logic last_of_run, protocol_error;

    // Classify requests and keep the checksum state
    gfb_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_cmd            (s_axis_tuser),
        .i_frame_class    (s_axis_tdata[7:0]),
        .i_message_id     (s_axis_tdata[15:8]),
        .i_payload_length (s_axis_tdata[23:16]),
        .i_payload_byte   (s_axis_tdata[31:24]),
        .i_queue_full     (q_full),
        .o_push           (q_push),
        .o_job            (push_job)
    );

    // Buffer jobs between the two sides
    gfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    // Serialise jobs into frame bytes
    gfb_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_valid      (q_valid),
        .i_job            (head_job),
        .o_pop            (q_pop),
        .o_valid          (m_axis_tvalid),
        .i_ready          (m_axis_tready),
        .o_frame_byte     (m_axis_tdata),
        .o_frame_end      (m_axis_tlast),
        .o_last_of_run    (last_of_run),
        .o_protocol_error (protocol_error)
    );

    assign m_axis_tuser = {protocol_error, last_of_run};

endmodule

`default_nettype wire

// File: bench/tb_gnss_binary_frame_builder.sv
// ============================================================================
// tb_gnss_binary_frame_builder
// Self-checking bench for the binary command frame builder.
// ============================================================================
// Header and payload requests go in on the slave stream. An in-bench model of
// the framing and the 8-bit Fletcher checksum queues the bytes each request
// should produce. Every byte leaving the master stream is checked field by
// field against the oldest queued byte. Covered here: directed corner
// frames, protocol errors, abandoned frames, the longest frame, a long
// receiver hold-off that fills the block, random traffic and a final
// back-to-back stretch with no idling.
// ============================================================================

module tb_gnss_binary_frame_builder;

    import gfb_pkg::*;

    localparam int CLK_PERIOD       = 8;
    localparam int RESET_CYCLES     = 9;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int RANDOM_ITEMS     = 150;
    localparam int DRAIN_CYCLES     = 32;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int MAX_PRINTED      = 50;

    // One byte on the wire with its side-band flags
    typedef struct packed {
        logic [7:0] wire_byte;
        logic       closes;
        logic       last_of_run;
        logic       protocol_error;
    } t_frame_byte;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;

    // Bytes still owed by the block, oldest first
    t_frame_byte expected_bytes[$];

    // Model state: running checksum and open frame
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    logic [7:0] payload_left;
    logic       frame_open;

    int  mismatches;
    int  results_seen;
    int  requests_sent;
    int  cycle_count;
    int  hold_left;
    int  stall_left;
    bit  tx_idle_on;
    bit  rx_idle_on;

    gnss_binary_frame_builder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Watchdog: give up well beyond the slowest legal run
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Frame model
    // ------------------------------------------------------------------------

    task automatic owe_byte(input logic [7:0] b, input logic closes, input logic last_of_run,
                            input logic protocol_error);
        t_frame_byte fb;
        fb.wire_byte      = b;
        fb.closes         = closes;
        fb.last_of_run    = last_of_run;
        fb.protocol_error = protocol_error;
        expected_bytes.push_back(fb);
    endtask

    // Fold one byte into the Fletcher sums, both wrapping at 8 bits
    task automatic fold_checksum(input logic [7:0] b);
        ck_a = ck_a + b;
        ck_b = ck_b + ck_a;
    endtask

    // Queue the bytes one accepted request must produce and advance the model
    task automatic predict_frame_bytes(input logic cmd, input logic [7:0] frame_class,
                                       input logic [7:0] message_id,
                                       input logic [7:0] payload_length,
                                       input logic [7:0] payload_byte);
        logic [7:0] len_lo;
        if (cmd == CMD_HEADER) begin
            len_lo = (payload_length > MAX_PAYLOAD_LEN) ? MAX_PAYLOAD_LEN : payload_length;
            ck_a = 8'h00;
            ck_b = 8'h00;
            fold_checksum(frame_class);
            fold_checksum(message_id);
            fold_checksum(len_lo);
            fold_checksum(LEN_HIGH);
            owe_byte(SYNC_FIRST, 1'b0, 1'b0, 1'b0);
            owe_byte(SYNC_SECOND, 1'b0, 1'b0, 1'b0);
            owe_byte(frame_class, 1'b0, 1'b0, 1'b0);
            owe_byte(message_id, 1'b0, 1'b0, 1'b0);
            owe_byte(len_lo, 1'b0, 1'b0, 1'b0);
            owe_byte(LEN_HIGH, 1'b0, (len_lo != 8'h00), 1'b0);
            if (len_lo == 8'h00) begin
                // Empty frame: checksum follows the header at once
                owe_byte(ck_a, 1'b0, 1'b0, 1'b0);
                owe_byte(ck_b, 1'b1, 1'b1, 1'b0);
                frame_open   = 1'b0;
                payload_left = 8'h00;
            end else begin
                frame_open   = 1'b1;
                payload_left = len_lo;
            end
        end else if (!frame_open) begin
            // Stray payload: single flagged zero byte, state untouched
            owe_byte(8'h00, 1'b0, 1'b1, 1'b1);
        end else begin
            fold_checksum(payload_byte);
            payload_left = payload_left - 8'd1;
            owe_byte(payload_byte, 1'b0, (payload_left != 8'h00), 1'b0);
            if (payload_left == 8'h00) begin
                owe_byte(ck_a, 1'b0, 1'b0, 1'b0);
                owe_byte(ck_b, 1'b1, 1'b1, 1'b0);
                frame_open = 1'b0;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        if (mismatches < MAX_PRINTED)
            $display("mismatch on result %0d (cycle %0d): %s expected %0h got %0h",
                     results_seen, cycle_count, what, want, got);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_frame_byte want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch("byte with nothing owed, tdata", 8'h00, m_axis_tdata);
            end else begin
                want = expected_bytes.pop_front();
                if (m_axis_tdata !== want.wire_byte)
                    report_mismatch("frame_byte", want.wire_byte, m_axis_tdata);
                if (m_axis_tlast !== want.closes)
                    report_mismatch("frame_end", want.closes, m_axis_tlast);
                if (m_axis_tuser[0] !== want.last_of_run)
                    report_mismatch("last_of_run", want.last_of_run, m_axis_tuser[0]);
                if (m_axis_tuser[1] !== want.protocol_error)
                    report_mismatch("protocol_error", want.protocol_error, m_axis_tuser[1]);
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts plus an optional long hold-off
    // ------------------------------------------------------------------------

    initial begin
        m_axis_tready = 1'b0;
        hold_left     = 0;
        stall_left    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (stall_left == 0 && rx_idle_on && $urandom_range(0, 6) == 0)
                    stall_left = $urandom_range(1, 10);
                if (stall_left > 0) begin
                    stall_left--;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offer one request, hold it until taken, then model it. Valid stays high
    // into the next request unless an idle burst is drawn.
    task automatic send_request(input logic cmd, input logic [7:0] frame_class,
                                input logic [7:0] message_id,
                                input logic [7:0] payload_length,
                                input logic [7:0] payload_byte);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {payload_byte, payload_length, message_id, frame_class};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_frame_bytes(cmd, frame_class, message_id, payload_length, payload_byte);
        requests_sent++;
    endtask

    // Header request; the unused payload byte carries noise
    task automatic send_header(input logic [7:0] frame_class, input logic [7:0] message_id,
                               input logic [7:0] payload_length);
        send_request(CMD_HEADER, frame_class, message_id, payload_length,
                     8'($urandom_range(0, 255)));
    endtask

    // Payload request; the unused header fields carry noise
    task automatic send_payload(input logic [7:0] payload_byte);
        send_request(CMD_PAYLOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), payload_byte);
    endtask

    // Header followed by random payload, cut short after sent_bytes
    task automatic send_frame(input logic [7:0] payload_length, input int sent_bytes);
        send_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), payload_length);
        repeat (sent_bytes) send_payload(8'($urandom_range(0, 255)));
    endtask

    // Drop valid so the last request is not taken again, then drain
    task automatic wait_all_delivered();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Corner frames, stray payload and abandoned frames
    task automatic test_directed_frames();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        // Payload with nothing open, straight after reset
        send_payload(8'hFF);
        send_payload(8'h00);
        // Empty frames at the field extremes
        send_header(8'h00, 8'h00, 8'h00);
        send_header(8'hFF, 8'hFF, 8'h00);
        // Shortest non-empty frame
        send_header(8'h06, 8'h01, 8'h01);
        send_payload(8'hFF);
        send_header(8'h0A, 8'h04, 8'h02);
        send_payload(8'h00);
        send_payload(8'h5A);
        // Abandon an open frame with an empty header
        send_header(8'h01, 8'h02, 8'h03);
        send_payload(8'h11);
        send_header(8'h06, 8'h08, 8'h00);
        // Abandon with a new frame that then completes
        send_header(8'hAA, 8'h55, 8'h02);
        send_payload(8'hA5);
        send_header(8'h0F, 8'hF0, 8'h01);
        send_payload(8'h3C);
        // Payload after a properly closed frame
        send_payload(8'h81);
        // Large length that is then abandoned
        send_header(8'h80, 8'h7F, 8'hFE);
        send_payload(8'h01);
        send_payload(8'h80);
        send_header(8'h55, 8'hAA, 8'h00);
        wait_all_delivered();
    endtask

    // Longest legal frame, checksum wrapping many times
    task automatic test_longest_frame();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_frame(MAX_PAYLOAD_LEN, MAX_PAYLOAD_LEN);
        wait_all_delivered();
    endtask

    // Receiver holds off while requests keep coming, so the block stalls
    task automatic test_output_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_left  = LONG_HOLD_CYCLES;
        send_frame(8'd24, 24);
        send_header(8'h13, 8'h37, 8'h00);
        send_payload(8'h42);
        send_frame(8'd3, 3);
        wait_all_delivered();
    endtask

    // Mostly complete frames of random content, some noise and broken frames
    task automatic test_random_traffic();
        int start_count;
        int pick;
        int len;
        start_count = requests_sent;
        while (requests_sent - start_count < RANDOM_ITEMS) begin
            tx_idle_on = ($urandom_range(0, 4) != 0);
            rx_idle_on = ($urandom_range(0, 4) != 0);
            pick = $urandom_range(0, 9);
            len  = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 48) : $urandom_range(0, 6);
            if (pick == 0) begin
                send_payload(8'($urandom_range(0, 255)));
            end else if (pick == 1) begin
                // Truncated frame, left open for whatever comes next
                len = $urandom_range(2, 12);
                send_frame(8'(len), $urandom_range(0, len - 1));
            end else begin
                send_frame(8'(len), len);
            end
        end
        wait_all_delivered();
    endtask

    // Closing stretch: both sides flat out
    task automatic test_back_to_back();
        int len;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (10) begin
            len = $urandom_range(0, 8);
            send_frame(8'(len), len);
            if ($urandom_range(0, 2) == 0)
                send_payload(8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 32'h0;
        s_axis_tuser  = CMD_HEADER;
        tx_idle_on    = 1'b0;
        rx_idle_on    = 1'b0;
        mismatches    = 0;
        results_seen  = 0;
        requests_sent = 0;
        ck_a          = 8'h00;
        ck_b          = 8'h00;
        payload_left  = 8'h00;
        frame_open    = 1'b0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_frames();
        test_longest_frame();
        test_output_backpressure();
        test_random_traffic();
        test_back_to_back();

        // Drop valid and let the last bytes drain
        wait_all_delivered();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: files.f
design/gfb_pkg.sv
design/gfb_front.sv
design/gfb_queue.sv
design/gfb_back.sv
design/gnss_binary_frame_builder.sv
bench/tb_gnss_binary_frame_builder.sv
